/* hw/rtl/tpa_pkg.sv */
// Shared constants, codes and control types for the touch position averager.
package tpa_pkg;

    // Number of X/Y pairs averaged per reported position; a power of two.
    localparam int SAMPLE_PAIRS = 4;

    localparam int OP_W       = 3;
    localparam int RAW_W      = 12;
    localparam int TS_W       = 32;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SUM_W      = $clog2(SAMPLE_PAIRS * ((1 << RAW_W) - 1) + 1);
    localparam int AVG_SHIFT  = $clog2(SAMPLE_PAIRS);
    localparam int CNT_W      = $clog2(SAMPLE_PAIRS + 1);
    localparam int DIFF_W     = RAW_W + 1;
    localparam int SM1_W      = SIZE_W + 1;
    localparam int PROD_W     = DIFF_W + SM1_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam int S_TDATA_W  = ((RAW_W + TS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 3;

    // Event codes.
    localparam logic [OP_W-1:0] OP_PRESS   = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_AXIS_X  = 3'd2;
    localparam logic [OP_W-1:0] OP_AXIS_Y  = 3'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd6;

    // Register reset values.
    localparam logic [TS_W-1:0]   DEBOUNCE_RST = 32'd100000;
    localparam logic [RAW_W-1:0]  OFFSET_RST   = 12'd0;
    localparam logic [RAW_W-1:0]  RANGE_RST    = 12'd4095;
    localparam logic [SIZE_W-1:0] WIDTH_RST    = 13'd800;
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = 13'd480;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic complete;
        logic div_done;
    } t_status;

endpackage

/* hw/rtl/tpa_div.sv */
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module tpa_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tpa_pkg::PROD_W-1:0]   i_dividend,
    input  logic        [tpa_pkg::RAW_W-1:0]    i_divisor,
    output logic                                o_done,
    output logic        [tpa_pkg::POS_W-1:0]    o_quotient
);
    import tpa_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_quo;
    logic [RAW_W-1:0]     r_rem;
    logic [RAW_W-1:0]     r_div;
    logic                 r_neg;
    logic                 r_zero;

    logic [RAW_W:0]       trial;
    logic                 fits;
    logic [PROD_W-1:0]    magnitude;

    assign magnitude = i_dividend[PROD_W-1] ? (~i_dividend + PROD_W'(1)) : i_dividend;
    assign trial     = {r_rem, r_quo[PROD_W-1]};
    assign fits      = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= magnitude;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[PROD_W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], fits};
            r_rem <= fits ? RAW_W'(trial - {1'b0, r_div}) : trial[RAW_W-1:0];
        end
    end

    // Truncation toward zero: divide magnitudes, then restore the sign.
    always_comb begin
        if (r_zero) begin
            o_quotient = '0;
        end else if (r_neg) begin
            o_quotient = POS_W'(~r_quo[POS_W-1:0] + POS_W'(1));
        end else begin
            o_quotient = r_quo[POS_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

/* hw/rtl/tpa_datapath.sv */
// Datapath: configuration registers, touch bookkeeping, calibration and result register.
module tpa_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tpa_pkg::t_cmd                        i_cmd,
    output tpa_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [tpa_pkg::OP_W-1:0]             i_op,
    input  logic [tpa_pkg::RAW_W-1:0]            i_axis_value,
    input  logic [tpa_pkg::TS_W-1:0]             i_timestamp,
    output logic                                 o_accepted,
    output logic                                 o_touched,
    output logic                                 o_position_valid,
    output logic [tpa_pkg::POS_W-1:0]            o_pos_x,
    output logic [tpa_pkg::POS_W-1:0]            o_pos_y
);
    import tpa_pkg::*;

    // Configuration.
    logic [TS_W-1:0]   r_debounce;
    logic [RAW_W-1:0]  r_x_off, r_x_range, r_y_off, r_y_range;
    logic [SIZE_W-1:0] r_width, r_height;

    // Touch and averaging state.
    logic [TS_W-1:0]   r_press_time, n_press_time;
    logic              r_touch, n_touch;
    logic              r_have_x, n_have_x, r_have_y, n_have_y;
    logic [RAW_W-1:0]  r_latest_x, n_latest_x, r_latest_y, n_latest_y;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [POS_W-1:0]  r_cur_x, r_cur_y;

    // Per-event result and calibration pipeline.
    logic              r_res_acc, r_res_touch, r_res_valid;
    logic [RAW_W-1:0]  r_avg_x, r_avg_y;
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic              r_out_acc, r_out_touch, r_out_valid;
    logic [POS_W-1:0]  r_out_x, r_out_y;

    logic [TS_W-1:0]   elapsed;
    logic              acc, complete;
    logic [CNT_W:0]    cnt_inc;
    logic [RAW_W-1:0]  avg_x, avg_y;

    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [SM1_W-1:0]  sm1_x, sm1_y;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic              done_x, done_y;
    logic [POS_W-1:0]  q_x, q_y;

    always_comb begin
        n_press_time = r_press_time;
        n_touch      = r_touch;
        n_have_x     = r_have_x;
        n_have_y     = r_have_y;
        n_latest_x   = r_latest_x;
        n_latest_y   = r_latest_y;
        n_count      = r_count;
        n_sum_x      = r_sum_x;
        n_sum_y      = r_sum_y;
        acc          = 1'b0;
        complete     = 1'b0;
        cnt_inc      = '0;
        avg_x        = '0;
        avg_y        = '0;
        elapsed      = i_timestamp - r_press_time;

        if (i_op == OP_PRESS) begin
            n_press_time = i_timestamp;
            n_touch      = 1'b1;
            acc          = 1'b1;
        end else if (i_op == OP_RELEASE) begin
            if (elapsed >= r_debounce) begin
                n_touch = 1'b0;
                acc     = 1'b1;
            end
        end

        // Any event that leaves the touch released restarts the averaging window.
        if (!n_touch) begin
            n_count = '0;
            n_sum_x = '0;
            n_sum_y = '0;
        end

        if (i_op inside {OP_AXIS_X, OP_AXIS_Y}) begin
            acc = 1'b1;
            if (i_op == OP_AXIS_X) begin
                n_latest_x = i_axis_value;
                n_have_x   = 1'b1;
            end else begin
                n_latest_y = i_axis_value;
                n_have_y   = 1'b1;
            end
            if (n_have_x && n_have_y) begin
                n_have_x = 1'b0;
                n_have_y = 1'b0;
                n_sum_x  = n_sum_x + SUM_W'(n_latest_x);
                n_sum_y  = n_sum_y + SUM_W'(n_latest_y);
                cnt_inc  = {1'b0, n_count} + (CNT_W + 1)'(1);
                if (cnt_inc >= (CNT_W + 1)'(SAMPLE_PAIRS)) begin
                    complete = 1'b1;
                    avg_x    = RAW_W'(n_sum_x >> AVG_SHIFT);
                    avg_y    = RAW_W'(n_sum_y >> AVG_SHIFT);
                    n_count  = '0;
                    n_sum_x  = '0;
                    n_sum_y  = '0;
                end else begin
                    n_count = cnt_inc[CNT_W-1:0];
                end
            end
        end
    end

    // Calibration product: (avg - offset) * (size - 1), both signed.
    assign diff_x = $signed({1'b0, r_avg_x}) - $signed({1'b0, r_x_off});
    assign diff_y = $signed({1'b0, r_avg_y}) - $signed({1'b0, r_y_off});
    assign sm1_x  = $signed({1'b0, r_width}) - $signed(SM1_W'(1));
    assign sm1_y  = $signed({1'b0, r_height}) - $signed(SM1_W'(1));
    assign prod_x = diff_x * sm1_x;
    assign prod_y = diff_y * sm1_y;

    tpa_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_x),
        .i_divisor  (r_x_range),
        .o_done     (done_x),
        .o_quotient (q_x)
    );

    tpa_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_y),
        .i_divisor  (r_y_range),
        .o_done     (done_y),
        .o_quotient (q_y)
    );

    assign o_status.complete = complete;
    assign o_status.div_done = done_x & done_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_x_off    <= OFFSET_RST;
            r_x_range  <= RANGE_RST;
            r_y_off    <= OFFSET_RST;
            r_y_range  <= RANGE_RST;
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_X_OFFSET: r_x_off    <= i_cfg_data[RAW_W-1:0];
                CFG_X_RANGE:  r_x_range  <= i_cfg_data[RAW_W-1:0];
                CFG_Y_OFFSET: r_y_off    <= i_cfg_data[RAW_W-1:0];
                CFG_Y_RANGE:  r_y_range  <= i_cfg_data[RAW_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time <= '0;
            r_touch      <= 1'b0;
            r_have_x     <= 1'b0;
            r_have_y     <= 1'b0;
            r_latest_x   <= '0;
            r_latest_y   <= '0;
            r_count      <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_press_time <= n_press_time;
                r_touch      <= n_touch;
                r_have_x     <= n_have_x;
                r_have_y     <= n_have_y;
                r_latest_x   <= n_latest_x;
                r_latest_y   <= n_latest_y;
                r_count      <= n_count;
                r_sum_x      <= n_sum_x;
                r_sum_y      <= n_sum_y;
            end
            if (o_status.div_done) begin
                r_cur_x <= q_x;
                r_cur_y <= q_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_acc   <= acc;
            r_res_touch <= n_touch;
            r_res_valid <= complete;
            if (complete) begin
                r_avg_x <= avg_x;
                r_avg_y <= avg_y;
            end
        end
        if (i_cmd.mul) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
        if (i_cmd.emit) begin
            r_out_acc   <= r_res_acc;
            r_out_touch <= r_res_touch;
            r_out_valid <= r_res_valid;
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
        end
    end

    assign o_accepted       = r_out_acc;
    assign o_touched        = r_out_touch;
    assign o_position_valid = r_out_valid;
    assign o_pos_x          = r_out_x;
    assign o_pos_y          = r_out_y;

endmodule

/* hw/rtl/tpa_ctrl.sv */
// Controller: sequences one event through bookkeeping, multiply and divide (when it completes a position) and output.
module tpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  tpa_pkg::t_status  i_status,
    output tpa_pkg::t_cmd     o_cmd
);
    import tpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd.accept    = i_s_tvalid && (r_state == S_IDLE);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.emit      = (r_state == S_EMIT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = i_status.complete ? S_MUL : S_EMIT;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted word did not reach the output register");

    a_complete_goes_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_status.complete |=> r_state == S_MUL)
        else $error("completed pair window did not start calibration");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> !o_cmd.accept)
        else $error("event accepted while the divider is running");
`endif

endmodule

/* hw/rtl/touch_position_averager_core.sv */
// Top level of the touch position averager: stream ports, config port, control and datapath.
//
// The block takes touch events (press, release, X axis, Y axis, other) on a stream port
// and returns exactly one word per event: whether the event counted, the touched state
// after it, whether it completed a new averaged position, and the current calibrated
// X and Y screen coordinates. A release only clears the touched state once the
// debounce interval has passed since the press, measured with wrapping 32-bit time.
// X and Y readings are paired and summed; after four pairs the averages are mapped to
// screen coordinates as (avg - offset) * (size - 1) / range, truncated toward zero and
// not clamped, with a zero range giving zero. Events are handled one at a time. An
// event that does not complete a position has its result word loaded into the output
// register once that register is free, and the word is offered in the same cycle that
// the input is ready again. An event that completes a position first passes through
// the calibration multiply, the loading of the dividers, the two restoring dividers
// (X and Y run side by side, one quotient bit per cycle each) and the capture of the
// quotients, then waits for the output register in the same way. The output register
// lets a new event be accepted while the previous result word still waits for the
// consumer. Configuration registers are written through their own valid/ready channel,
// which is always ready, and should be written only while no event is in flight.
module touch_position_averager_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input events.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [11:0] axis_value, [43:12] timestamp, [47:44] zero
    input  logic [tpa_pkg::S_TDATA_W-1:0]        i_s_tdata,
    // [2:0] op
    input  logic [tpa_pkg::OP_W-1:0]             i_s_tuser,
    // Result words.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [24:0] pos_x, [49:25] pos_y, [55:50] zero
    output logic [tpa_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // [0] accepted, [1] touched, [2] position_valid
    output logic [tpa_pkg::M_TUSER_W-1:0]        o_m_tuser,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tpa_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic             accepted, touched, position_valid;
    logic [POS_W-1:0] pos_x, pos_y;

    assign o_cfg_ready = 1'b1;

    tpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tpa_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_s_tuser),
        .i_axis_value     (i_s_tdata[RAW_W-1:0]),
        .i_timestamp      (i_s_tdata[RAW_W+TS_W-1:RAW_W]),
        .o_accepted       (accepted),
        .o_touched        (touched),
        .o_position_valid (position_valid),
        .o_pos_x          (pos_x),
        .o_pos_y          (pos_y)
    );

    assign o_m_tdata = M_TDATA_W'({pos_y, pos_x});
    assign o_m_tuser = {position_valid, touched, accepted};

endmodule
